>>> rtl/srr_pkg.sv
package srr_pkg;

    localparam int WINDOW       = 4;
    localparam int SLOTS        = 8;
    localparam int PAYLOAD_BITS = 64;

    localparam int SEQ_W    = 16;
    localparam int WORD_W   = 64;
    localparam int SLOT_AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DRAIN_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DELIV,
        ST_ACK,
        ST_DRAIN
    } t_state;

    // Slot of a sequence number; SLOTS is a power of two, so this is a mask.
    function automatic logic [SLOT_AW-1:0] slot_of(input logic [SEQ_W-1:0] seq);
        return SLOT_AW'(seq % SLOTS);
    endfunction

endpackage

>>> rtl/selective_repeat_receiver.sv
// Selective-repeat ARQ receiver.
// Input channel s_*: one arriving packet per item. s_tuser carries the
// checksum-ok flag, s_tdata the sequence number and the payload word.
// Output channel m_*: one result per item. m_tuser is the kind (0 delivery,
// 1 acknowledgement), m_tdata holds the payload word and the ack number,
// m_tlast marks the final result caused by one input packet.
// Corrupt and out-of-window packets give no result. A packet at the window
// base gives a delivery, an ack and up to WINDOW-1 drained deliveries.
// Timing: a packet is taken, then its results leave one per cycle into
// the output register whenever that register is free. Each drained slot
// is first read from the payload memory into a read register and then
// moved from there into the output register.
// The input side is ready only while no packet is in work; it stays ready
// while the last result of the previous packet waits in the output register.
// A stall on m_tready holds the result and the sequencer in place.
// Reset clears the window base, the slot valid bits and both channels at
// once; there is no clearing pass and the block is ready in the next cycle.
module selective_repeat_receiver (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // [15:0] seq_num, [79:16] payload
    input  logic         s_tuser,   // [0] checksum_ok
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,   // [63:0] payload_res, [79:64] ack_num
    output logic         m_tuser,   // [0] kind
    output logic         m_tlast
);

    localparam int SEQ_W   = srr_pkg::SEQ_W;
    localparam int WORD_W  = srr_pkg::WORD_W;
    localparam int SLOT_AW = srr_pkg::SLOT_AW;
    localparam int DRAIN_W = srr_pkg::DRAIN_W;
    localparam int PBITS   = srr_pkg::PAYLOAD_BITS;

    // Control state
    srr_pkg::t_state r_state, n_state;
    logic [SEQ_W-1:0]          r_base, n_base;
    logic [srr_pkg::SLOTS-1:0] r_valid, n_valid;
    logic [SEQ_W-1:0]          r_cur, n_cur;
    logic [DRAIN_W-1:0]        r_drained, n_drained;
    logic                      r_match, n_match;

    // Item being worked on
    logic [SEQ_W-1:0] r_seq, n_seq;
    logic [PBITS-1:0] r_word, n_word;

    // Output register
    logic              r_m_valid, n_m_valid;
    logic              r_m_kind, n_m_kind;
    logic [WORD_W-1:0] r_m_word, n_m_word;
    logic [SEQ_W-1:0]  r_m_ack, n_m_ack;
    logic              r_m_last, n_m_last;

    // Payload memory with a registered read port
    logic [PBITS-1:0] mem [srr_pkg::SLOTS];
    logic [PBITS-1:0] r_rd_data;
    logic             mem_we, mem_re;
    logic [SLOT_AW-1:0] mem_wa, mem_ra;

    // Helpers
    logic [SEQ_W-1:0] in_seq;
    logic [PBITS-1:0] in_word;
    logic             in_ok;
    logic [SEQ_W:0]   base_x, seq_x;
    logic             out_free;
    logic [SEQ_W-1:0] nb, nb1;
    logic [srr_pkg::SLOTS-1:0] valid_after;

    assign in_ok   = s_tuser;
    assign in_seq  = s_tdata[15:0];
    assign in_word = PBITS'(s_tdata[79:16]);
    assign base_x  = {1'b0, r_base};
    assign seq_x   = {1'b0, in_seq};
    assign out_free = !r_m_valid || m_tready;

    // Sequence number drained in this step and the one after it, the next base
    assign nb  = r_cur + SEQ_W'(1);
    assign nb1 = nb + SEQ_W'(1);

    always_comb begin
        valid_after = r_valid;
        valid_after[srr_pkg::slot_of(nb)] = 1'b0;
        valid_after[srr_pkg::slot_of(nb + SEQ_W'(srr_pkg::WINDOW))] = 1'b0;
    end

    always_comb begin
        n_state   = r_state;
        n_base    = r_base;
        n_valid   = r_valid;
        n_cur     = r_cur;
        n_drained = r_drained;
        n_match   = r_match;
        n_seq     = r_seq;
        n_word    = r_word;
        n_m_valid = r_m_valid && !m_tready;
        n_m_kind  = r_m_kind;
        n_m_word  = r_m_word;
        n_m_ack   = r_m_ack;
        n_m_last  = r_m_last;
        mem_we    = 1'b0;
        mem_wa    = srr_pkg::slot_of(in_seq);
        mem_re    = 1'b0;
        mem_ra    = srr_pkg::slot_of(r_seq + SEQ_W'(1));
        s_tready  = (r_state == srr_pkg::ST_IDLE);

        case (r_state)
            srr_pkg::ST_IDLE: begin
                if (s_tvalid && in_ok) begin
                    n_seq  = in_seq;
                    n_word = in_word;
                    if (in_seq == r_base) begin
                        n_match = 1'b1;
                        n_state = srr_pkg::ST_DELIV;
                    end else if (seq_x > base_x &&
                                 seq_x < base_x + (SEQ_W+1)'(srr_pkg::WINDOW)) begin
                        // Buffer inside the window, then ack
                        mem_we  = 1'b1;
                        n_valid[srr_pkg::slot_of(in_seq)] = 1'b1;
                        n_match = 1'b0;
                        n_state = srr_pkg::ST_ACK;
                    end else if (seq_x < base_x &&
                                 seq_x + (SEQ_W+1)'(srr_pkg::WINDOW) >= base_x) begin
                        n_match = 1'b0;
                        n_state = srr_pkg::ST_ACK;
                    end
                end
            end

            srr_pkg::ST_DELIV: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = srr_pkg::KIND_DELIVER;
                    n_m_word  = WORD_W'(r_word);
                    n_m_ack   = '0;
                    n_m_last  = 1'b0;
                    n_valid[srr_pkg::slot_of(r_seq)] = 1'b0;
                    n_state   = srr_pkg::ST_ACK;
                end
            end

            srr_pkg::ST_ACK: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = srr_pkg::KIND_ACK;
                    n_m_word  = '0;
                    n_m_ack   = r_seq;
                    n_m_last  = 1'b1;
                    n_state   = srr_pkg::ST_IDLE;
                    if (r_match) begin
                        if (srr_pkg::WINDOW > 1 &&
                            r_valid[srr_pkg::slot_of(r_seq + SEQ_W'(1))]) begin
                            // Fetch the first buffered word to drain
                            n_m_last  = 1'b0;
                            mem_re    = 1'b1;
                            n_cur     = r_seq;
                            n_drained = '0;
                            n_state   = srr_pkg::ST_DRAIN;
                        end else begin
                            n_base = r_seq + SEQ_W'(1);
                        end
                    end
                end
            end

            srr_pkg::ST_DRAIN: begin
                mem_ra = srr_pkg::slot_of(nb1);
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = srr_pkg::KIND_DELIVER;
                    n_m_word  = WORD_W'(r_rd_data);
                    n_m_ack   = '0;
                    n_valid   = valid_after;
                    n_cur     = nb;
                    n_drained = r_drained + DRAIN_W'(1);
                    if ((int'(r_drained) + 1 >= srr_pkg::WINDOW - 1) ||
                        !valid_after[srr_pkg::slot_of(nb1)]) begin
                        n_m_last = 1'b1;
                        n_base   = nb1;
                        n_state  = srr_pkg::ST_IDLE;
                    end else begin
                        // Advance to the next buffered slot
                        n_m_last = 1'b0;
                        mem_re   = 1'b1;
                    end
                end
            end

            default: begin
                n_state = srr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= srr_pkg::ST_IDLE;
            r_base    <= '0;
            r_valid   <= '0;
            r_cur     <= '0;
            r_drained <= '0;
            r_match   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_base    <= n_base;
            r_valid   <= n_valid;
            r_cur     <= n_cur;
            r_drained <= n_drained;
            r_match   <= n_match;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq    <= n_seq;
        r_word   <= n_word;
        r_m_kind <= n_m_kind;
        r_m_word <= n_m_word;
        r_m_ack  <= n_m_ack;
        r_m_last <= n_m_last;
    end

    // Writes happen only on accept, reads only as a drain starts or goes on: no overlap
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= in_word;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tuser  = r_m_kind;
    assign m_tdata  = {r_m_ack, r_m_word};
    assign m_tlast  = r_m_last;

    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == srr_pkg::ST_DRAIN |-> int'(r_drained) < srr_pkg::WINDOW - 1)
        else $error("drain ran past the window bound");

    a_drain_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == srr_pkg::ST_DRAIN |-> r_valid[srr_pkg::slot_of(r_cur + SEQ_W'(1))])
        else $error("draining a slot that is not buffered");

    a_match_at_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srr_pkg::ST_DELIV || (r_state == srr_pkg::ST_ACK && r_match))
        |-> r_seq == r_base)
        else $error("in-order delivery with a sequence number off the base");

    a_base_stable_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srr_pkg::ST_DELIV ||
         (r_state == srr_pkg::ST_DRAIN && n_state == srr_pkg::ST_DRAIN))
        |=> $stable(r_base))
        else $error("window base moved before the drain finished");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

typedef struct {
    logic                       kind;
    logic [srr_pkg::WORD_W-1:0] word;
    logic [srr_pkg::SEQ_W-1:0]  ack;
    logic                       last;
} t_arq_result;

// Tracks the receive window and the results each packet should cause.
class rx_window_checker;
    logic [srr_pkg::SEQ_W-1:0]  rx_base;
    bit                         buf_valid [srr_pkg::SLOTS];
    logic [srr_pkg::WORD_W-1:0] buf_word  [srr_pkg::SLOTS];
    t_arq_result                due_results [$];
    int unsigned                errors;

    function new();
        rx_base = '0;
        foreach (buf_valid[i]) begin
            buf_valid[i] = 1'b0;
            buf_word[i]  = '0;
        end
        errors = 0;
    endfunction

    function void push_result(logic kind, logic [srr_pkg::WORD_W-1:0] word,
                              logic [srr_pkg::SEQ_W-1:0] ack);
        t_arq_result r;
        r.kind = kind;
        r.word = word;
        r.ack  = ack;
        r.last = 1'b0;
        due_results.push_back(r);
    endfunction

    // Note one accepted packet; return how many results it causes.
    function int accept_packet(logic ok, logic [srr_pkg::SEQ_W-1:0] seq,
                               logic [srr_pkg::WORD_W-1:0] word);
        int unsigned                cur;
        int unsigned                s;
        int unsigned                nb;
        int unsigned                drained;
        int                         size_at_entry;
        t_arq_result                tail;
        logic [srr_pkg::WORD_W-1:0] kept;
        size_at_entry = due_results.size();
        kept    = srr_pkg::WORD_W'(((65'd1 << srr_pkg::PAYLOAD_BITS) - 65'd1) & {1'b0, word});
        cur     = rx_base;
        s       = seq;
        drained = 0;
        if (!ok)
            return 0;
        if (s == cur) begin
            push_result(srr_pkg::KIND_DELIVER, kept, '0);
            push_result(srr_pkg::KIND_ACK, '0, seq);
            buf_valid[cur % srr_pkg::SLOTS] = 1'b0;
            nb = (cur + 1) & 32'hFFFF;
            // Drain consecutive buffered words, at most WINDOW-1 of them.
            while (drained < srr_pkg::WINDOW - 1 && buf_valid[nb % srr_pkg::SLOTS]) begin
                cur = nb;
                push_result(srr_pkg::KIND_DELIVER, buf_word[nb % srr_pkg::SLOTS], '0);
                buf_valid[nb % srr_pkg::SLOTS] = 1'b0;
                buf_valid[(cur + srr_pkg::WINDOW) % srr_pkg::SLOTS] = 1'b0;
                drained++;
                nb = (cur + 1) & 32'hFFFF;
            end
            rx_base = srr_pkg::SEQ_W'(cur + 1);
        end else if (s > cur && s < cur + srr_pkg::WINDOW) begin
            buf_valid[s % srr_pkg::SLOTS] = 1'b1;
            buf_word[s % srr_pkg::SLOTS]  = kept;
            push_result(srr_pkg::KIND_ACK, '0, seq);
        end else if (s < cur && s + srr_pkg::WINDOW >= cur) begin
            push_result(srr_pkg::KIND_ACK, '0, seq);
        end else begin
            return 0;
        end
        tail = due_results.pop_back();
        tail.last = 1'b1;
        due_results.push_back(tail);
        return due_results.size() - size_at_entry;
    endfunction

    function void compare(string field, logic [srr_pkg::WORD_W-1:0] want,
                          logic [srr_pkg::WORD_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
        end
    endfunction

    function void check_result(logic kind, logic [srr_pkg::WORD_W-1:0] word,
                               logic [srr_pkg::SEQ_W-1:0] ack, logic last);
        t_arq_result want;
        if (due_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual kind %0d word %h ack %h last %0d",
                     $time, kind, word, ack, last);
            return;
        end
        want = due_results.pop_front();
        compare("kind", srr_pkg::WORD_W'(want.kind), srr_pkg::WORD_W'(kind));
        compare("payload", want.word, word);
        compare("ack_num", srr_pkg::WORD_W'(want.ack), srr_pkg::WORD_W'(ack));
        compare("last", srr_pkg::WORD_W'(want.last), srr_pkg::WORD_W'(last));
    endfunction
endclass

module tb;

    localparam int RANDOM_ITEMS = 282;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 80;
    localparam int IDLE_PCT     = 34;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;     // [15:0] seq_num, [79:16] payload
    logic        s_tuser  = 1'b0;   // [0] checksum_ok
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;           // [63:0] payload_res, [79:64] ack_num
    logic        m_tuser;           // [0] kind
    logic        m_tlast;

    rx_window_checker sb = new();

    bit s_idle_on = 1'b1;
    bit m_idle_on = 1'b1;
    bit hold_req  = 1'b0;
    int quiet_cycles = 0;

    selective_repeat_receiver dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 i_clk = ~i_clk;

    // Offer one packet, idling first at random, and hold it until taken.
    task automatic send_packet(input logic ok, input logic [srr_pkg::SEQ_W-1:0] seq,
                               input logic [srr_pkg::WORD_W-1:0] word, output int caused);
        while (s_idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {word, seq};
        s_tuser  <= ok;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        caused = sb.accept_packet(ok, seq, word);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : result_side
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_tready <= !(m_idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[63:0], m_tdata[79:64], m_tlast);
    end

    // End the run when nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("tb failed");
            $finish;
        end
    end

    initial begin : stimulus
        int                         caused;
        int                         sent;
        int                         off;
        int                         seq_i;
        bit                         pressure_done;
        logic                       ok;
        logic [srr_pkg::SEQ_W-1:0]  seq;
        logic [srr_pkg::WORD_W-1:0] word;

        pressure_done = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corrupt, far above, buffering, duplicate, full drain,
        // re-ack, edge of window, a delivery with no drain, a partial drain, below re-ack range.
        send_packet(1'b0, 16'd0,     '1, caused);
        send_packet(1'b1, 16'hFFFF,  '0, caused);
        send_packet(1'b1, 16'd2,     64'h0123_4567_89AB_CDEF, caused);
        send_packet(1'b1, 16'd3,     '1, caused);
        send_packet(1'b1, 16'd3,     64'hDEAD_BEEF_0000_0003, caused);
        send_packet(1'b1, 16'd1,     64'h8000_0000_0000_0001, caused);
        send_packet(1'b1, 16'd0,     '0, caused);
        send_packet(1'b1, 16'd0,     64'h1111_1111_1111_1111, caused);
        send_packet(1'b1, 16'd3,     64'h2222_2222_2222_2222, caused);
        send_packet(1'b1, 16'd8,     64'h3333_3333_3333_3333, caused);
        send_packet(1'b1, 16'd7,     64'h4444_4444_4444_4444, caused);
        send_packet(1'b1, 16'd4,     '1, caused);
        send_packet(1'b1, 16'd6,     64'h6666_6666_6666_6666, caused);
        send_packet(1'b1, 16'd5,     64'h5555_5555_5555_5555, caused);
        send_packet(1'b0, 16'd8,     64'hAAAA_AAAA_AAAA_AAAA, caused);
        send_packet(1'b1, 16'd0,     64'h7777_7777_7777_7777, caused);
        send_packet(1'b1, 16'd4,     64'h9999_9999_9999_9999, caused);
        send_packet(1'b1, 16'd8,     64'h5555_5555_5555_5555, caused);

        // Random: mostly packets near the window base, some noise.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            s_idle_on = !(sent >= 100 && sent < 170);
            m_idle_on = s_idle_on;
            if (sent >= 220 && !pressure_done) begin
                hold_req      = 1'b1;
                pressure_done = 1'b1;
            end
            case ($urandom_range(9))
                0:       word = '0;
                1:       word = '1;
                default: word = {$urandom, $urandom};
            endcase
            if ($urandom_range(99) < 10) begin
                ok  = 1'($urandom_range(1));
                seq = srr_pkg::SEQ_W'($urandom);
            end else begin
                ok    = ($urandom_range(99) < 92);
                off   = int'($urandom_range(8)) - 5;
                seq_i = int'(sb.rx_base) + off;
                if (seq_i < 0)
                    seq_i = int'($urandom_range(3));
                seq = srr_pkg::SEQ_W'(seq_i);
            end
            send_packet(ok, seq, word, caused);
            sent++;
        end
        s_tvalid <= 1'b0;
        m_idle_on = 1'b1;

        while (sb.due_results.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (sb.errors == 0 && sb.due_results.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/srr_pkg.sv
rtl/selective_repeat_receiver.sv
sim/tb.sv
